### hw/rtl/efd_pkg.sv
// Shared types and constants for the escaped frame deframer.
// Depends on nothing; every other file of the block imports it.
package efd_pkg;

   // Largest frame length that the byte count reports; it saturates here.
   localparam logic [9:0] MaxFrameBytes = 10'd512;

   // Result status codes.
   typedef enum logic [2:0] {
      STATUS_DATA     = 3'd0,
      STATUS_OK       = 3'd1,
      STATUS_BAD_SUM  = 3'd2,
      STATUS_BAD_CMD  = 3'd3,
      STATUS_ABORT    = 3'd4,
      STATUS_EMPTY    = 3'd5
   } efd_status_type;

   // Register indexes of the configuration port (byte address / 4).
   typedef enum logic [2:0] {
      REG_CHECK_ENABLE    = 3'd0,
      REG_DLE_BYTE        = 3'd1,
      REG_ESC_BYTE        = 3'd2,
      REG_STX_BYTE        = 3'd3,
      REG_ETX_BYTE        = 3'd4,
      REG_BEM_START_BYTE  = 3'd5,
      REG_BEM_END_BYTE    = 3'd6,
      REG_RECEIVE_COMMAND = 3'd7
   } efd_reg_type;

   // Configuration register values as seen by the parser.
   typedef struct packed {
      logic       check_enable;
      logic [7:0] dle_byte;
      logic [7:0] esc_byte;
      logic [7:0] stx_byte;
      logic [7:0] etx_byte;
      logic [7:0] bem_start_byte;
      logic [7:0] bem_end_byte;
      logic [7:0] receive_command;
   } efd_cfg_type;

   // One result item.
   typedef struct packed {
      logic [7:0]     out_byte;
      efd_status_type frame_status;
      logic [9:0]     frame_length;
   } efd_result_type;

endpackage

### hw/rtl/escaped_frame_deframer_core.sv
// Escaped frame deframer top level: configuration registers, parser, result buffer.
// A transferred byte enters the input register; its result, decoded combinationally,
// goes to the buffer's output register. Throughput: one byte per cycle unless stalled.
// The two-entry result buffer absorbs results while the output stalls; once both
// entries are full the input stalls. Reset is synchronous and active high; it restores
// the register defaults and clears the frame state; there is no clearing pass.
module escaped_frame_deframer_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_byte,
   output logic [2:0]  rsp_frame_status,
   output logic [9:0]  rsp_frame_length,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import efd_pkg::*;

   efd_cfg_type    cfg;
   efd_result_type res;
   efd_result_type rsp_data;
   logic           res_valid;
   logic           buf_full;

   efd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   efd_parse u_parse (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data_byte (req_data_byte),
      .buf_full      (buf_full),
      .res_valid     (res_valid),
      .res           (res)
   );

   efd_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .res_valid (res_valid),
      .res       (res),
      .buf_full  (buf_full),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // Result fields onto their ports.
   assign rsp_out_byte     = rsp_data.out_byte;
   assign rsp_frame_status = rsp_data.frame_status;
   assign rsp_frame_length = rsp_data.frame_length;

endmodule

### hw/rtl/efd_csr.sv
// Configuration registers of the deframer behind an APB-style port.
// Depends on efd_pkg for the register indexes and the configuration struct.
module efd_csr (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [4:0]          csr_paddr,
   input  logic [31:0]         csr_pwdata,
   output logic [31:0]         csr_prdata,
   output logic                csr_pready,
   output efd_pkg::efd_cfg_type cfg
);
   import efd_pkg::*;

   efd_cfg_type cfg_ff;
   efd_cfg_type cfg_in;
   efd_reg_type reg_index;
   logic        write_strobe;

   assign csr_pready   = 1'b1;
   assign reg_index    = efd_reg_type'(csr_paddr[4:2]);
   assign write_strobe = csr_psel && csr_penable && csr_pwrite;
   assign cfg          = cfg_ff;

   // Register write decode; a write lands in the access cycle.
   always_comb begin
      cfg_in = cfg_ff;
      if (write_strobe) begin
         unique case (reg_index)
            REG_CHECK_ENABLE:    cfg_in.check_enable    = csr_pwdata[0];
            REG_DLE_BYTE:        cfg_in.dle_byte        = csr_pwdata[7:0];
            REG_ESC_BYTE:        cfg_in.esc_byte        = csr_pwdata[7:0];
            REG_STX_BYTE:        cfg_in.stx_byte        = csr_pwdata[7:0];
            REG_ETX_BYTE:        cfg_in.etx_byte        = csr_pwdata[7:0];
            REG_BEM_START_BYTE:  cfg_in.bem_start_byte  = csr_pwdata[7:0];
            REG_BEM_END_BYTE:    cfg_in.bem_end_byte    = csr_pwdata[7:0];
            REG_RECEIVE_COMMAND: cfg_in.receive_command = csr_pwdata[7:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   // Read-back multiplexer.
   always_comb begin
      unique case (reg_index)
         REG_CHECK_ENABLE:    csr_prdata = {31'd0, cfg_ff.check_enable};
         REG_DLE_BYTE:        csr_prdata = {24'd0, cfg_ff.dle_byte};
         REG_ESC_BYTE:        csr_prdata = {24'd0, cfg_ff.esc_byte};
         REG_STX_BYTE:        csr_prdata = {24'd0, cfg_ff.stx_byte};
         REG_ETX_BYTE:        csr_prdata = {24'd0, cfg_ff.etx_byte};
         REG_BEM_START_BYTE:  csr_prdata = {24'd0, cfg_ff.bem_start_byte};
         REG_BEM_END_BYTE:    csr_prdata = {24'd0, cfg_ff.bem_end_byte};
         REG_RECEIVE_COMMAND: csr_prdata = {24'd0, cfg_ff.receive_command};
         default:             csr_prdata = 32'd0;
      endcase
   end

   // Registers with their reset values.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.check_enable    <= 1'b1;
         cfg_ff.dle_byte        <= 8'd16;
         cfg_ff.esc_byte        <= 8'd27;
         cfg_ff.stx_byte        <= 8'd2;
         cfg_ff.etx_byte        <= 8'd3;
         cfg_ff.bem_start_byte  <= 8'd1;
         cfg_ff.bem_end_byte    <= 8'd10;
         cfg_ff.receive_command <= 8'd147;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

### hw/rtl/efd_parse.sv
// Input register, frame state and per-byte decode of the deframer.
// Depends on efd_pkg for the configuration, status and result types.
module efd_parse (
   input  logic                   clock,
   input  logic                   reset,
   input  efd_pkg::efd_cfg_type   cfg,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [7:0]             req_data_byte,
   input  logic                   buf_full,
   output logic                   res_valid,
   output efd_pkg::efd_result_type res
);
   import efd_pkg::*;

   logic       s1_valid_ff, s1_valid_in;
   logic [7:0] s1_byte_ff;
   logic       escape_pending_ff, escape_pending_in;
   logic       in_frame_ff, in_frame_in;
   logic [7:0] byte_sum_ff, byte_sum_in;
   logic [7:0] first_byte_ff, first_byte_in;
   logic [9:0] byte_count_ff, byte_count_in;
   logic       advance;
   logic       accept;
   logic       is_escape;
   logic       do_start, do_end, do_take, do_abort, do_clear;
   logic [9:0] count_next;
   efd_status_type end_status;

   // The held byte moves on whenever the output buffer can take a result.
   assign advance   = s1_valid_ff && !buf_full;
   assign req_stall = s1_valid_ff && buf_full;
   assign accept    = req_valid && !req_stall;
   assign is_escape = (s1_byte_ff == cfg.dle_byte) || (s1_byte_ff == cfg.esc_byte);

   // Saturating byte count after taking one more data byte.
   assign count_next = (byte_count_ff < MaxFrameBytes) ? byte_count_ff + 10'd1
                                                       : byte_count_ff;

   // Frame verdict: empty first, then checksum, then command.
   always_comb begin
      priority if (byte_count_ff == 10'd0) end_status = STATUS_EMPTY;
      else if (cfg.check_enable && (byte_sum_ff != 8'd0)) end_status = STATUS_BAD_SUM;
      else if (first_byte_ff != cfg.receive_command) end_status = STATUS_BAD_CMD;
      else end_status = STATUS_OK;
   end

   // Decode of the held byte against the escape state.
   always_comb begin
      do_start          = 1'b0;
      do_end            = 1'b0;
      do_take           = 1'b0;
      do_abort          = 1'b0;
      do_clear          = 1'b0;
      escape_pending_in = escape_pending_ff;
      if (advance) begin
         if (escape_pending_ff) begin
            escape_pending_in = 1'b0;
            priority if (s1_byte_ff == cfg.stx_byte && !in_frame_ff) do_start = 1'b1;
            else if (s1_byte_ff == cfg.etx_byte && in_frame_ff) do_end = 1'b1;
            else if (s1_byte_ff == cfg.bem_start_byte && !in_frame_ff) do_start = 1'b1;
            else if (s1_byte_ff == cfg.bem_end_byte && in_frame_ff) do_end = 1'b1;
            else if (is_escape && in_frame_ff) do_take = 1'b1;
            else if (in_frame_ff) do_abort = 1'b1;
            else do_clear = 1'b1;
         end else if (is_escape) begin
            escape_pending_in = 1'b1;
         end else if (in_frame_ff) begin
            do_take = 1'b1;
         end
      end
   end

   // Frame state update and the result that goes with it.
   always_comb begin
      in_frame_in   = in_frame_ff;
      byte_sum_in   = byte_sum_ff;
      first_byte_in = first_byte_ff;
      byte_count_in = byte_count_ff;
      res_valid     = 1'b0;
      res.out_byte     = 8'd0;
      res.frame_status = STATUS_DATA;
      res.frame_length = byte_count_ff;
      if (do_start || do_end || do_abort || do_clear) begin
         in_frame_in   = do_start;
         byte_sum_in   = 8'd0;
         first_byte_in = 8'd0;
         byte_count_in = 10'd0;
      end
      if (do_take) begin
         if (byte_count_ff == 10'd0) begin
            first_byte_in = s1_byte_ff;
         end
         byte_sum_in      = byte_sum_ff + s1_byte_ff;
         byte_count_in    = count_next;
         res_valid        = 1'b1;
         res.out_byte     = s1_byte_ff;
         res.frame_length = count_next;
      end
      if (do_end) begin
         res_valid        = 1'b1;
         res.frame_status = end_status;
      end
      if (do_abort) begin
         res_valid        = 1'b1;
         res.frame_status = STATUS_ABORT;
      end
   end

   assign s1_valid_in = accept || (s1_valid_ff && !advance);

   // Input register and frame state.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff       <= 1'b0;
         escape_pending_ff <= 1'b0;
         in_frame_ff       <= 1'b0;
         byte_sum_ff       <= 8'd0;
         first_byte_ff     <= 8'd0;
         byte_count_ff     <= 10'd0;
      end else begin
         s1_valid_ff       <= s1_valid_in;
         escape_pending_ff <= escape_pending_in;
         in_frame_ff       <= in_frame_in;
         byte_sum_ff       <= byte_sum_in;
         first_byte_ff     <= first_byte_in;
         byte_count_ff     <= byte_count_in;
      end
   end

   // The byte itself needs no reset.
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_byte_ff <= req_data_byte;
      end
   end

endmodule

### hw/rtl/efd_out_buf.sv
// Two-entry result buffer: an output register and a skid register.
// Depends on efd_pkg for the result type.
module efd_out_buf (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    res_valid,
   input  efd_pkg::efd_result_type res,
   output logic                    buf_full,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output efd_pkg::efd_result_type rsp_data
);
   import efd_pkg::*;

   logic           head_valid_ff, head_valid_in;
   logic           skid_valid_ff, skid_valid_in;
   efd_result_type head_ff, head_in;
   efd_result_type skid_ff, skid_in;
   logic           pop;

   assign pop       = head_valid_ff && !rsp_stall;
   assign buf_full  = skid_valid_ff;
   assign rsp_valid = head_valid_ff;
   assign rsp_data  = head_ff;

   // A new result only arrives while the skid register is empty.
   always_comb begin
      head_valid_in = head_valid_ff;
      skid_valid_in = skid_valid_ff;
      head_in       = head_ff;
      skid_in       = skid_ff;
      if (pop) begin
         if (skid_valid_ff) begin
            head_in       = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            head_valid_in = res_valid;
            head_in       = res;
         end
      end else if (res_valid) begin
         if (!head_valid_ff) begin
            head_valid_in = 1'b1;
            head_in       = res;
         end else begin
            skid_valid_in = 1'b1;
            skid_in       = res;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         head_valid_ff <= head_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;
      skid_ff <= skid_in;
   end

endmodule

### tb/sv/efd_scoreboard_pkg.sv
`timescale 1ns / 100ps
// Scoreboard for the escaped frame deframer: a bit-exact predictor of the parser plus
// the queue of frame results still owed by the block. Depends on efd_pkg for types.
package efd_scoreboard_pkg;
   import efd_pkg::*;

   // Only the first ten mismatches are printed; later ones are only counted.
   localparam int ReportLimit = 10;

   class deframe_scoreboard;
      efd_cfg_type    regs;
      logic           escape_seen;
      logic           in_frame;
      logic [7:0]     byte_sum;
      logic [7:0]     first_byte;
      logic [9:0]     byte_count;
      efd_result_type expected_results[$];
      int unsigned    mismatches;
      int unsigned    results_checked;
      int unsigned    status_tally[8];

      function new();
         regs.check_enable    = 1'b1;
         regs.dle_byte        = 8'd16;
         regs.esc_byte        = 8'd27;
         regs.stx_byte        = 8'd2;
         regs.etx_byte        = 8'd3;
         regs.bem_start_byte  = 8'd1;
         regs.bem_end_byte    = 8'd10;
         regs.receive_command = 8'd147;
         escape_seen = 1'b0;
         clear_frame();
      endfunction

      // Mirror a register write; only the register's own width is kept.
      function void write_register(efd_reg_type idx, logic [31:0] word);
         case (idx)
            REG_CHECK_ENABLE:    regs.check_enable    = word[0];
            REG_DLE_BYTE:        regs.dle_byte        = word[7:0];
            REG_ESC_BYTE:        regs.esc_byte        = word[7:0];
            REG_STX_BYTE:        regs.stx_byte        = word[7:0];
            REG_ETX_BYTE:        regs.etx_byte        = word[7:0];
            REG_BEM_START_BYTE:  regs.bem_start_byte  = word[7:0];
            REG_BEM_END_BYTE:    regs.bem_end_byte    = word[7:0];
            REG_RECEIVE_COMMAND: regs.receive_command = word[7:0];
            default: ;
         endcase
      endfunction

      function void clear_frame();
         in_frame   = 1'b0;
         byte_sum   = 8'd0;
         first_byte = 8'd0;
         byte_count = 10'd0;
      endfunction

      function void add_result(logic [7:0] value, efd_status_type st, logic [9:0] len);
         efd_result_type entry;
         entry = '{out_byte: value, frame_status: st, frame_length: len};
         expected_results = {expected_results, entry};
         status_tally[st]++;
      endfunction

      // A data byte joins the frame; the length saturates but the sum keeps counting.
      function void take_data(logic [7:0] value);
         if (byte_count == 10'd0)
            first_byte = value;
         byte_sum = byte_sum + value;
         if (byte_count < MaxFrameBytes)
            byte_count++;
         add_result(value, STATUS_DATA, byte_count);
      endfunction

      // Frame end checks run in order: empty, then checksum, then command.
      function void close_frame();
         efd_status_type st;
         if (byte_count == 10'd0)
            st = STATUS_EMPTY;
         else if (regs.check_enable && byte_sum != 8'd0)
            st = STATUS_BAD_SUM;
         else if (first_byte != regs.receive_command)
            st = STATUS_BAD_CMD;
         else
            st = STATUS_OK;
         add_result(8'd0, st, byte_count);
         clear_frame();
         escape_seen = 1'b0;
      endfunction

      // Predict what one transferred stream byte causes.
      function void take_stream_byte(logic [7:0] ch);
         logic [9:0] len;
         if (escape_seen) begin
            escape_seen = 1'b0;
            // Escape codes are tested in a fixed order, so overlapping codes resolve here.
            if (ch == regs.stx_byte && !in_frame) begin
               clear_frame();
               in_frame = 1'b1;
            end else if (ch == regs.etx_byte && in_frame) begin
               close_frame();
            end else if (ch == regs.bem_start_byte && !in_frame) begin
               clear_frame();
               in_frame = 1'b1;
            end else if (ch == regs.bem_end_byte && in_frame) begin
               close_frame();
            end else if ((ch == regs.dle_byte || ch == regs.esc_byte) && in_frame) begin
               take_data(ch);
            end else if (in_frame) begin
               len = byte_count;
               clear_frame();
               add_result(8'd0, STATUS_ABORT, len);
            end else begin
               clear_frame();
            end
         end else if (ch == regs.dle_byte || ch == regs.esc_byte) begin
            escape_seen = 1'b1;
         end else if (in_frame) begin
            take_data(ch);
         end
      endfunction

      function void note_failure(string detail);
         mismatches++;
         if (mismatches <= ReportLimit)
            $display("Mismatch: %s", detail);
      endfunction

      // Compare one transferred result with the oldest expectation.
      function void check_result(efd_result_type got);
         efd_result_type want;
         results_checked++;
         if (expected_results.size() == 0) begin
            note_failure($sformatf("unexpected result byte=%0d status=%0d length=%0d",
                                   got.out_byte, got.frame_status, got.frame_length));
         end else begin
            want = expected_results.pop_front();
            if (got.out_byte != want.out_byte || got.frame_status != want.frame_status ||
                got.frame_length != want.frame_length)
               note_failure($sformatf(
                  "byte exp %0d got %0d, status exp %0d got %0d, length exp %0d got %0d",
                  want.out_byte, got.out_byte, want.frame_status, got.frame_status,
                  want.frame_length, got.frame_length));
         end
      endfunction
   endclass

endpackage

### tb/sv/escaped_frame_deframer_core_tb.sv
`timescale 1ns / 100ps
// Top-level testbench of the escaped frame deframer: clock, reset, stream and register
// drivers, result monitor and watchdog. Depends on efd_pkg and efd_scoreboard_pkg.
module escaped_frame_deframer_core_tb;
   import efd_pkg::*;
   import efd_scoreboard_pkg::*;

   localparam int StallLimit   = 5000;
   localparam int HoldCycles   = 400;
   localparam int SettleCycles = 4;
   localparam int LongFrameLen = 515;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte = 8'd0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_out_byte;
   logic [2:0]  rsp_frame_status;
   logic [9:0]  rsp_frame_length;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [4:0]  csr_paddr = 5'd0;
   logic [31:0] csr_pwdata = 32'd0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   deframe_scoreboard frames;
   int unsigned send_idle_pct = 0;
   int unsigned recv_stall_pct = 0;
   int unsigned output_hold_left = 0;
   int unsigned bytes_sent = 0;
   int unsigned settings_used = 1;
   int unsigned quiet_cycles = 0;

   escaped_frame_deframer_core dut (.*);

   // 100 MHz clock.
   initial begin
      forever #5 clock = ~clock;
   end

   // Receiver: random stalls, or a long hold-off when one is requested.
   initial begin
      forever begin
         @(posedge clock);
         if (output_hold_left > 0) begin
            rsp_stall <= 1'b1;
            output_hold_left--;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_stall_pct);
         end
      end
   end

   // Monitor both channels at the clock edge and watch for a hung run.
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall)
         frames.take_stream_byte(req_data_byte);
      if (!reset && rsp_valid && !rsp_stall)
         frames.check_result('{out_byte: rsp_out_byte,
                               frame_status: efd_status_type'(rsp_frame_status),
                               frame_length: rsp_frame_length});
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= StallLimit) begin
         $display("Timeout: no transfer for %0d cycles", StallLimit);
         $display("Verification failed");
         $finish;
      end
   end

   // Offer one stream byte, with random idle cycles ahead of it, and wait for the transfer.
   task automatic send_byte(input logic [7:0] value);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= value;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      bytes_sent++;
   endtask

   // Frame payload byte; values that collide with an escape code get stuffed.
   task automatic send_data(input logic [7:0] value);
      if (value == frames.regs.dle_byte || value == frames.regs.esc_byte)
         send_byte($urandom_range(1) ? frames.regs.dle_byte : frames.regs.esc_byte);
      send_byte(value);
   endtask

   // A well-formed frame in a random style; mostly the right command, often a good sum.
   task automatic send_random_frame();
      logic [7:0] lead;
      logic [7:0] body;
      logic [7:0] sum;
      int         count;
      lead = $urandom_range(1) ? frames.regs.dle_byte : frames.regs.esc_byte;
      send_byte(lead);
      send_byte($urandom_range(1) ? frames.regs.stx_byte : frames.regs.bem_start_byte);
      count = ($urandom_range(9) == 0) ? 0 : $urandom_range(12, 1);
      sum = 8'd0;
      for (int i = 0; i < count; i++) begin
         if (i == 0 && $urandom_range(3) != 0)
            body = frames.regs.receive_command;
         else if (i == count - 1 && $urandom_range(1))
            body = 8'd0 - sum;
         else
            body = 8'($urandom);
         send_data(body);
         sum = sum + body;
      end
      send_byte($urandom_range(1) ? frames.regs.dle_byte : frames.regs.esc_byte);
      send_byte($urandom_range(1) ? frames.regs.etx_byte : frames.regs.bem_end_byte);
   endtask

   // Mostly frames, with raw noise and stray escapes that drop or abort.
   task automatic run_random(input int unsigned count);
      int unsigned stop_at;
      stop_at = bytes_sent + count;
      while (bytes_sent < stop_at) begin
         case ($urandom_range(9))
            0: repeat ($urandom_range(6, 1)) send_byte(8'($urandom));
            1: begin
               send_byte($urandom_range(1) ? frames.regs.dle_byte : frames.regs.esc_byte);
               send_byte(8'($urandom));
            end
            default: send_random_frame();
         endcase
      end
   endtask

   // Wait until every expected result has come out, then let the block settle.
   task automatic wait_for_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (frames.expected_results.size() != 0)
         @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   // One register write: setup cycle, then access until pready. The select stays up
   // so that writes run back to back; apply_settings drops it after the last one.
   task automatic csr_write(input efd_reg_type idx, input logic [7:0] value);
      logic [31:0] word;
      word = $urandom();
      if (idx == REG_CHECK_ENABLE)
         word[0] = value[0];
      else
         word[7:0] = value;
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= word;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready)
         @(posedge clock);
      frames.write_register(idx, word);
   endtask

   task automatic apply_settings(input efd_cfg_type cfg);
      wait_for_idle();
      csr_write(REG_CHECK_ENABLE, {7'd0, cfg.check_enable});
      csr_write(REG_DLE_BYTE, cfg.dle_byte);
      csr_write(REG_ESC_BYTE, cfg.esc_byte);
      csr_write(REG_STX_BYTE, cfg.stx_byte);
      csr_write(REG_ETX_BYTE, cfg.etx_byte);
      csr_write(REG_BEM_START_BYTE, cfg.bem_start_byte);
      csr_write(REG_BEM_END_BYTE, cfg.bem_end_byte);
      csr_write(REG_RECEIVE_COMMAND, cfg.receive_command);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      settings_used++;
   endtask

   // Main sequence.
   initial begin
      efd_cfg_type cfg;
      logic [7:0]  directed_bytes[$];
      frames = new();
      // Default codes: good frame with a stuffed escape, abort by an escaped start,
      // dropped stray escape, empty frame, bad checksum with a stuffed escape.
      directed_bytes = '{8'd16, 8'd2, 8'd147, 8'd16, 8'd16, 8'd93, 8'd16, 8'd3,
                         8'd27, 8'd1, 8'd0, 8'd27, 8'd2,
                         8'd16, 8'd9,
                         8'd27, 8'd1, 8'd27, 8'd10,
                         8'd16, 8'd2, 8'd255, 8'd27, 8'd27, 8'd27, 8'd10};
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Sender idles often, receiver stalls more.
      send_idle_pct = 35;
      recv_stall_pct = 58;
      foreach (directed_bytes[i])
         send_byte(directed_bytes[i]);
      run_random(50);

      // Extreme codes, checking off; start and end codes overlap the escapes.
      cfg = '{check_enable: 1'b0, dle_byte: 8'h00, esc_byte: 8'hFF, stx_byte: 8'h00,
              etx_byte: 8'hFF, bem_start_byte: 8'hFF, bem_end_byte: 8'h00,
              receive_command: 8'h00};
      apply_settings(cfg);
      run_random(40);

      // Roles swapped: one shared escape, start equal to end, checking on.
      send_idle_pct = 58;
      recv_stall_pct = 35;
      cfg = '{check_enable: 1'b1, dle_byte: 8'h7E, esc_byte: 8'h7E, stx_byte: 8'h55,
              etx_byte: 8'h55, bem_start_byte: 8'h80, bem_end_byte: 8'h01,
              receive_command: 8'hFF};
      apply_settings(cfg);
      run_random(40);

      // Default codes without checking, and one frame past the length limit.
      cfg = '{check_enable: 1'b0, dle_byte: 8'd16, esc_byte: 8'd27, stx_byte: 8'd2,
              etx_byte: 8'd3, bem_start_byte: 8'd1, bem_end_byte: 8'd10,
              receive_command: 8'($urandom)};
      apply_settings(cfg);
      send_byte(frames.regs.dle_byte);
      send_byte(frames.regs.stx_byte);
      repeat (LongFrameLen) send_data(8'($urandom));
      send_byte(frames.regs.dle_byte);
      send_byte(frames.regs.etx_byte);
      run_random(25);

      // Full rate; the output is held off for a while so the block backs up.
      send_idle_pct = 0;
      recv_stall_pct = 0;
      cfg.check_enable = 1'b1;
      cfg.receive_command = 8'd147;
      apply_settings(cfg);
      output_hold_left = HoldCycles;
      run_random(50);

      // Random register settings.
      repeat (3) begin
         cfg = '{check_enable: 1'($urandom_range(1)), dle_byte: 8'($urandom),
                 esc_byte: 8'($urandom), stx_byte: 8'($urandom), etx_byte: 8'($urandom),
                 bem_start_byte: 8'($urandom), bem_end_byte: 8'($urandom),
                 receive_command: 8'($urandom)};
         apply_settings(cfg);
         run_random(12);
      end

      wait_for_idle();
      $display("Sent %0d stream bytes under %0d register settings; %0d results checked.",
               bytes_sent, settings_used, frames.results_checked);
      $display("Frame ends: %0d accepted, %0d bad sum, %0d wrong command, %0d aborted, %0d empty.",
               frames.status_tally[STATUS_OK], frames.status_tally[STATUS_BAD_SUM],
               frames.status_tally[STATUS_BAD_CMD], frames.status_tally[STATUS_ABORT],
               frames.status_tally[STATUS_EMPTY]);
      if (frames.mismatches == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
